FILE: sv/fcs_pkg.sv
`default_nettype none
package fcs_pkg;

  localparam int MAX_JOINTS_DEF    = 16;
  localparam int JOINT_COUNT_RESET = 8;
  localparam int LINK_LENGTH_RESET = 32;
  localparam int SQRT_STEPS        = 29;  // 58-bit radicand, two bits a step
  localparam int DIV_STEPS         = 22;  // offset magnitude stays below 2^22
  localparam int CFG_W             = 12;

  localparam logic CFG_JOINT_COUNT = 1'b0;
  localparam logic CFG_LINK_LENGTH = 1'b1;

  localparam logic signed [25:0] Q_MAX = 26'sd8388607;
  localparam logic signed [25:0] Q_MIN = -26'sd8388608;

  typedef struct packed {
    logic               mode;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] anchor_x;
    logic signed [23:0] anchor_y;
  } in_t;

  typedef struct packed {
    logic [3:0]         joint_index;
    logic signed [23:0] joint_x;
    logic signed [23:0] joint_y;
    logic               last;
  } out_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_LAYOUT, ST_PIN_HEAD, ST_READ, ST_DIFF, ST_MUL, ST_SUM,
    ST_SQRT, ST_DIV_INIT, ST_DIV, ST_WRITE, ST_PIN_TAIL, ST_OUT_READ, ST_OUT_LOAD
  } state_t;

  typedef enum logic [1:0] {
    WR_POINT, WR_ANCHOR, WR_LAYOUT, WR_PLACE
  } wr_sel_t;

  typedef struct packed {
    logic    load_in;
    logic    rd_en;
    logic    diff_en;
    logic    mul_en;
    logic    sum_en;
    logic    sqrt_step;
    logic    div_init;
    logic    div_step;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    lay_first;
    logic    out_load;
    logic    out_last;
  } cmd_t;

  typedef struct packed {
    logic zero;
    logic sqrt_done;
    logic div_done;
    logic out_free;
  } sts_t;

  function automatic logic signed [23:0] sat24(input logic signed [25:0] v);
    if (v > Q_MAX) return Q_MAX[23:0];
    if (v < Q_MIN) return Q_MIN[23:0];
    return v[23:0];
  endfunction

endpackage
`default_nettype wire

FILE: sv/fcs_ctrl.sv
`default_nettype none
module fcs_ctrl
  import fcs_pkg::*;
#(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF,
  localparam int JW = $clog2(MAX_JOINTS),
  localparam int CW = $clog2(MAX_JOINTS + 1)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  input  wire logic          in_mode,
  input  wire logic [4:0]    joint_count,
  input  wire sts_t          sts,
  output cmd_t               cmd,
  output logic [JW-1:0]      addr_m,
  output logic [JW-1:0]      addr_r,
  output logic [JW-1:0]      wr_addr
);

  state_t        state, state_next;
  logic [JW-1:0] idx, idx_next;
  logic [CW-1:0] n, n_next;
  logic          bwd, bwd_next;
  logic [JW-1:0] n_last;

  assign n_last = JW'(n - 1'b1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      idx   <= '0;
      n     <= CW'(2);
      bwd   <= 1'b0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      n     <= n_next;
      bwd   <= bwd_next;
    end
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    n_next     = n;
    bwd_next   = bwd;
    cmd        = '0;
    cmd.wr_sel = WR_PLACE;
    in_ready   = 1'b0;
    addr_m     = idx;
    addr_r     = bwd ? JW'(idx + 1'b1) : JW'(idx - 1'b1);
    wr_addr    = idx;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          if (joint_count < 5'd2) n_next = CW'(2);
          else if (32'(joint_count) > 32'(MAX_JOINTS)) n_next = CW'(MAX_JOINTS);
          else n_next = CW'(joint_count);
          idx_next   = '0;
          bwd_next   = 1'b0;
          state_next = in_mode ? ST_PIN_HEAD : ST_LAYOUT;
        end
      end
      ST_LAYOUT: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = WR_LAYOUT;
        cmd.lay_first = (idx == '0);
        if (idx == n_last) begin
          idx_next   = '0;
          state_next = ST_OUT_READ;
        end else begin
          idx_next = JW'(idx + 1'b1);
        end
      end
      ST_PIN_HEAD: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_POINT;
        wr_addr    = '0;
        idx_next   = JW'(1);
        state_next = ST_READ;
      end
      ST_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_DIFF;
      end
      ST_DIFF: begin
        cmd.diff_en = 1'b1;
        state_next  = ST_MUL;
      end
      ST_MUL: begin
        cmd.mul_en = 1'b1;
        state_next = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = sts.zero ? ST_WRITE : ST_SQRT;
      end
      ST_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) state_next = ST_DIV_INIT;
      end
      ST_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_done) state_next = ST_WRITE;
      end
      ST_WRITE: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_PLACE;
        if (!bwd) begin
          if (idx == n_last) state_next = ST_PIN_TAIL;
          else begin
            idx_next   = JW'(idx + 1'b1);
            state_next = ST_READ;
          end
        end else begin
          if (idx == '0) state_next = ST_OUT_READ;
          else begin
            idx_next   = JW'(idx - 1'b1);
            state_next = ST_READ;
          end
        end
      end
      ST_PIN_TAIL: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = WR_ANCHOR;
        wr_addr    = n_last;
        bwd_next   = 1'b1;
        idx_next   = JW'(n_last - 1'b1);
        state_next = ST_READ;
      end
      ST_OUT_READ: begin
        cmd.rd_en  = 1'b1;
        state_next = ST_OUT_LOAD;
      end
      ST_OUT_LOAD: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_last = (idx == n_last);
          if (idx == n_last) state_next = ST_IDLE;
          else begin
            idx_next   = JW'(idx + 1'b1);
            state_next = ST_OUT_READ;
          end
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

FILE: sv/fcs_dp.sv
`default_nettype none
module fcs_dp
  import fcs_pkg::*;
#(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF,
  localparam int JW = $clog2(MAX_JOINTS)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire in_t           in_data,
  input  wire logic [11:0]   link_length,
  input  wire cmd_t          cmd,
  input  wire logic [JW-1:0] addr_m,
  input  wire logic [JW-1:0] addr_r,
  input  wire logic [JW-1:0] wr_addr,
  output sts_t               sts,
  output logic               out_valid,
  input  wire logic          out_ready,
  output out_t               out_data
);

  logic signed [23:0] mem_x [MAX_JOINTS];
  logic signed [23:0] mem_y [MAX_JOINTS];
  logic [MAX_JOINTS-1:0] vld;

  in_t                in_q;
  logic signed [23:0] ra_x, ra_y, rb_x, rb_y;
  logic signed [23:0] rx, ry, lay_x, lay_y;
  logic [24:0]        ax, ay;
  logic               neg_x, neg_y, zero;
  logic [49:0]        sqx, sqy;
  logic [36:0]        nx, ny;
  logic [57:0]        rad;
  logic [31:0]        srem;
  logic [28:0]        root;
  logic [4:0]         scnt, dcnt;
  logic [28:0]        drem_x, drem_y;
  logic [21:0]        dnum_x, dnum_y, quo_x, quo_y;

  logic signed [24:0] dx, dy;
  logic [50:0]        sq_sum;
  logic [31:0]        s_cand, s_trial;
  logic [49:0]        num_x, num_y;
  logic [29:0]        d_cand_x, d_cand_y;
  logic signed [23:0] wx, wy;
  logic signed [25:0] off_x, off_y;

  // registered read, entries never written read as zero
  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      ra_x <= vld[addr_m] ? mem_x[addr_m] : '0;
      ra_y <= vld[addr_m] ? mem_y[addr_m] : '0;
      rb_x <= vld[addr_r] ? mem_x[addr_r] : '0;
      rb_y <= vld[addr_r] ? mem_y[addr_r] : '0;
    end
    if (cmd.wr_en) begin
      mem_x[wr_addr] <= wx;
      mem_y[wr_addr] <= wy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (cmd.wr_en) vld[wr_addr] <= 1'b1;
  end

  assign dx = 25'(ra_x) - 25'(rb_x);
  assign dy = 25'(ra_y) - 25'(rb_y);

  always_ff @(posedge clk) begin
    if (cmd.load_in) in_q <= in_data;
    if (cmd.diff_en) begin
      rx    <= rb_x;
      ry    <= rb_y;
      neg_x <= dx[24];
      neg_y <= dy[24];
      ax    <= dx[24] ? 25'(-dx) : 25'(dx);
      ay    <= dy[24] ? 25'(-dy) : 25'(dy);
      zero  <= (dx == '0) && (dy == '0);
    end
    if (cmd.mul_en) begin
      sqx <= ax * ax;
      sqy <= ay * ay;
      nx  <= 37'(ax) * 37'(link_length);
      ny  <= 37'(ay) * 37'(link_length);
    end
  end

  // square root, two radicand bits per step
  assign sq_sum  = 51'(sqx) + 51'(sqy);
  assign s_cand  = {srem[29:0], rad[57:56]};
  assign s_trial = {1'b0, root, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      rad  <= {sq_sum[49:0], 8'd0};
      srem <= '0;
      root <= '0;
      scnt <= '0;
    end else if (cmd.sqrt_step) begin
      rad  <= {rad[55:0], 2'b00};
      scnt <= 5'(scnt + 1'b1);
      if (s_cand >= s_trial) begin
        srem <= s_cand - s_trial;
        root <= {root[27:0], 1'b1};
      end else begin
        srem <= s_cand;
        root <= {root[27:0], 1'b0};
      end
    end
  end

  // rounded quotient; top numerator bits preload the remainder (quotient < 2^22)
  assign num_x    = {1'b0, nx, 12'd0} + 50'(root[28:1]);
  assign num_y    = {1'b0, ny, 12'd0} + 50'(root[28:1]);
  assign d_cand_x = {drem_x, dnum_x[21]};
  assign d_cand_y = {drem_y, dnum_y[21]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      drem_x <= {1'b0, num_x[49:22]};
      drem_y <= {1'b0, num_y[49:22]};
      dnum_x <= num_x[21:0];
      dnum_y <= num_y[21:0];
      dcnt   <= '0;
    end else if (cmd.div_step) begin
      dnum_x <= {dnum_x[20:0], 1'b0};
      dnum_y <= {dnum_y[20:0], 1'b0};
      dcnt   <= 5'(dcnt + 1'b1);
      if (d_cand_x >= 30'(root)) begin
        drem_x <= 29'(d_cand_x - 30'(root));
        quo_x  <= {quo_x[20:0], 1'b1};
      end else begin
        drem_x <= d_cand_x[28:0];
        quo_x  <= {quo_x[20:0], 1'b0};
      end
      if (d_cand_y >= 30'(root)) begin
        drem_y <= 29'(d_cand_y - 30'(root));
        quo_y  <= {quo_y[20:0], 1'b1};
      end else begin
        drem_y <= d_cand_y[28:0];
        quo_y  <= {quo_y[20:0], 1'b0};
      end
    end
  end

  always_comb begin
    if (zero) begin
      off_x = '0;
      off_y = 26'({link_length, 8'd0});
    end else begin
      off_x = neg_x ? -26'(quo_x) : 26'(quo_x);
      off_y = neg_y ? -26'(quo_y) : 26'(quo_y);
    end
    case (cmd.wr_sel)
      WR_POINT: begin
        wx = in_q.point_x;
        wy = in_q.point_y;
      end
      WR_ANCHOR: begin
        wx = in_q.anchor_x;
        wy = in_q.anchor_y;
      end
      WR_LAYOUT: begin
        if (cmd.lay_first) begin
          wx = in_q.point_x;
          wy = in_q.point_y;
        end else begin
          wx = lay_x;
          wy = sat24(26'(lay_y) + 26'({link_length, 8'd0}));
        end
      end
      WR_PLACE: begin
        wx = sat24(26'(rx) + off_x);
        wy = sat24(26'(ry) + off_y);
      end
      default: begin
        wx = '0;
        wy = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en && cmd.wr_sel == WR_LAYOUT) begin
      lay_x <= wx;
      lay_y <= wy;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.out_load) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data.joint_index <= 4'(addr_m);
      out_data.joint_x     <= ra_x;
      out_data.joint_y     <= ra_y;
      out_data.last        <= cmd.out_last;
    end
  end

  assign sts.zero      = zero;
  assign sts.sqrt_done = (scnt == 5'(SQRT_STEPS - 1));
  assign sts.div_done  = (dcnt == 5'(DIV_STEPS - 1));
  assign sts.out_free  = !out_valid || out_ready;

endmodule
`default_nettype wire

FILE: sv/fabrik_chain_solver_top.sv
// channel   signals                         transfer when
// in        in_valid/in_ready, in_data      in_valid & in_ready
// out       out_valid/out_ready, out_data   out_valid & out_ready
// cfg       cfg_wr_en, cfg_addr, cfg_wdata  cfg_wr_en (no wait)
// Layout: one write per joint, then each joint is read and reported.
// Solve: head pin, 2n-2 placements (read, difference, multiply, sum, 29-step square
// root, divide setup, 22-step divide, write; a coincident joint goes from sum straight
// to write), tail pin, then each joint is read and reported.
// Reset clears the chain to zero through per-joint valid bits; no clearing pass.
// A stalled output holds its register; one item is worked on at a time.
`default_nettype none
module fabrik_chain_solver_top
  import fcs_pkg::*;
#(
  parameter int MAX_JOINTS = MAX_JOINTS_DEF
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_t              in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_t                  out_data,
  input  wire logic             cfg_wr_en,
  input  wire logic             cfg_addr,
  input  wire logic [CFG_W-1:0] cfg_wdata
);

  localparam int JW = $clog2(MAX_JOINTS);

  logic [4:0]    joint_count;
  logic [11:0]   link_length;
  cmd_t          cmd;
  sts_t          sts;
  logic [JW-1:0] addr_m, addr_r, wr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      joint_count <= 5'(JOINT_COUNT_RESET);
      link_length <= 12'(LINK_LENGTH_RESET);
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        CFG_JOINT_COUNT: joint_count <= cfg_wdata[4:0];
        CFG_LINK_LENGTH: link_length <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  fcs_ctrl #(.MAX_JOINTS(MAX_JOINTS)) u_ctrl (
    .clk, .rst, .in_valid, .in_ready,
    .in_mode(in_data.mode), .joint_count, .sts, .cmd,
    .addr_m, .addr_r, .wr_addr
  );

  fcs_dp #(.MAX_JOINTS(MAX_JOINTS)) u_dp (
    .clk, .rst, .in_data, .link_length, .cmd, .addr_m, .addr_r, .wr_addr,
    .sts, .out_valid, .out_ready, .out_data
  );

endmodule
`default_nettype wire

FILE: sv/fcs_checker.sv
`default_nettype none
module fcs_checker
  import fcs_pkg::*;
(
  input wire logic clk,
  input wire logic rst,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready,
  input wire out_t out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  a_idle_last: assert property (@(posedge clk) disable iff (rst)
    in_ready && out_valid |-> out_data.last)
    else $error("idle with a non-final joint pending");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind fabrik_chain_solver_top fcs_checker u_fcs_checker (
  .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .out_data
);
`default_nettype wire

FILE: verif/tb_fabrik_chain_solver_top.sv
`timescale 1ns / 1ps
module tb_fabrik_chain_solver_top;
  import fcs_pkg::*;

  localparam int NJ        = 16;
  localparam int IDLE_MAX  = 20000;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_ready;
  in_t              in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  out_t             out_data;
  logic             cfg_wr_en = 1'b0;
  logic             cfg_addr = CFG_JOINT_COUNT;
  logic [CFG_W-1:0] cfg_wdata = '0;

  fabrik_chain_solver_top dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_wr_en(cfg_wr_en), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  // chain model
  logic signed [23:0] chain_x [NJ];
  logic signed [23:0] chain_y [NJ];
  logic [4:0]         joints_cfg = 5'd8;
  logic [11:0]        link_cfg = 12'd32;
  out_t               joint_q [$];

  int errors = 0;
  int burst_left = 0;
  bit no_gaps = 0;
  int rx_style = 0;
  int hold_req = 0;
  int idle_cycles = 0;

  function automatic logic signed [23:0] clamp24(longint v);
    if (v > 64'sd8388607) return 24'sh7FFFFF;
    if (v < -64'sd8388608) return 24'sh800000;
    return v[23:0];
  endfunction

  function automatic longint unsigned root64(longint unsigned n);
    longint unsigned res, bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res;
  endfunction

  // move joint m to one link length from joint r, along the line between them
  function automatic void pull_joint(int m, int r);
    longint rx, ry, dx, dy, ox, oy;
    longint unsigned ax, ay, q, sx, sy, len;
    rx = chain_x[r];
    ry = chain_y[r];
    dx = longint'(chain_x[m]) - rx;
    dy = longint'(chain_y[m]) - ry;
    len = longint'(link_cfg) << 8;
    if (dx == 0 && dy == 0) begin
      ox = 0;
      oy = len;
    end else begin
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      q = root64((ax * ax + ay * ay) << 8);
      sx = (ax * len * 16 + q / 2) / q;
      sy = (ay * len * 16 + q / 2) / q;
      ox = dx < 0 ? -longint'(sx) : longint'(sx);
      oy = dy < 0 ? -longint'(sy) : longint'(sy);
    end
    chain_x[m] = clamp24(rx + ox);
    chain_y[m] = clamp24(ry + oy);
  endfunction

  function automatic void solve_chain(in_t item);
    int n;
    out_t r;
    n = joints_cfg < 2 ? 2 : (joints_cfg > NJ ? NJ : int'(joints_cfg));
    chain_x[0] = item.point_x;
    chain_y[0] = item.point_y;
    if (!item.mode) begin
      for (int i = 1; i < n; i++) begin
        chain_x[i] = chain_x[i-1];
        chain_y[i] = clamp24(longint'(chain_y[i-1]) + (longint'(link_cfg) << 8));
      end
    end else begin
      for (int i = 1; i < n; i++) pull_joint(i, i - 1);
      chain_x[n-1] = item.anchor_x;
      chain_y[n-1] = item.anchor_y;
      for (int i = n - 1; i > 0; i--) pull_joint(i - 1, i);
    end
    for (int i = 0; i < n; i++) begin
      r.joint_index = i[3:0];
      r.joint_x = chain_x[i];
      r.joint_y = chain_y[i];
      r.last = (i == n - 1);
      joint_q.push_back(r);
    end
  endfunction

  task automatic send_item(in_t item);
    if (!no_gaps && burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = $urandom_range(1, 8);
    end
    if (burst_left > 0) burst_left--;
    in_valid <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (!in_ready);
    solve_chain(item);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (joint_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, int val);
    drain();
    cfg_wr_en <= 1'b1;
    cfg_addr <= idx;
    cfg_wdata <= val[CFG_W-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    if (idx == CFG_JOINT_COUNT) joints_cfg = val[4:0];
    else link_cfg = val[11:0];
  endtask

  function automatic logic signed [23:0] rand_coord();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2, 3: return 24'($urandom());
      default: return $signed(24'($urandom_range(0, 2 * 51200))) - 24'sd51200;
    endcase
  endfunction

  function automatic in_t rand_item(int solve_pct);
    in_t it;
    it.mode = ($urandom_range(0, 99) < solve_pct);
    it.point_x = rand_coord();
    it.point_y = rand_coord();
    it.anchor_x = rand_coord();
    it.anchor_y = rand_coord();
    return it;
  endfunction

  function automatic in_t mk(int m, int px, int py, int ax, int ay);
    in_t it;
    it.mode = m[0];
    it.point_x = px[23:0];
    it.point_y = py[23:0];
    it.anchor_x = ax[23:0];
    it.anchor_y = ay[23:0];
    return it;
  endfunction

  task automatic test_directed();
    // coincident joints straight out of reset
    send_item(mk(1, 0, 0, 0, 0));
    send_item(mk(0, 0, 0, 0, 0));
    send_item(mk(1, 1000, -2000, 1000, -2000));
    write_reg(CFG_LINK_LENGTH, 4095);
    send_item(mk(0, 24'h7FFFFF, 24'h7FFFFF, 0, 0));      // layout saturates
    send_item(mk(0, -8388608, -8388608, 0, 0));
    send_item(mk(1, 8388607, 8388607, -8388608, -8388608));
    send_item(mk(1, -8388608, 8388607, 8388607, -8388608));
    write_reg(CFG_LINK_LENGTH, 0);
    send_item(mk(1, 12345, -54321, -777, 999));
    send_item(mk(0, 256, 256, 0, 0));
    write_reg(CFG_JOINT_COUNT, 0);
    write_reg(CFG_LINK_LENGTH, 1);
    send_item(mk(0, 5, 5, 0, 0));
    send_item(mk(1, -5, 3, 100, 100));
    write_reg(CFG_JOINT_COUNT, 1);
    send_item(mk(1, 0, 0, 0, 0));
    write_reg(CFG_JOINT_COUNT, 31);
    write_reg(CFG_LINK_LENGTH, 2048);
    send_item(mk(0, 0, -8388608, 0, 0));
    send_item(mk(1, 0, 0, 0, 0));
    write_reg(CFG_JOINT_COUNT, 17);
    send_item(mk(1, 8388607, -8388608, 256, -256));
    write_reg(CFG_JOINT_COUNT, 2);
    send_item(mk(1, 5000, 5000, 5000, 5000));
    send_item(mk(0, 8388607, 0, 0, 0));
  endtask

  task automatic test_random_sweep();
    int jc [8] = '{2, 3, 5, 4, 16, 0, 31, 6};
    int ll [8] = '{1, 32, 4095, 0, 100, 7, 2048, 17};
    int cnt;
    for (int p = 0; p < 8; p++) begin
      write_reg(CFG_JOINT_COUNT, jc[p]);
      write_reg(CFG_LINK_LENGTH, ll[p]);
      no_gaps = (p % 3 == 2);
      rx_style = p % 3;
      cnt = (jc[p] == 16 || jc[p] == 31) ? 12 : 67;
      for (int k = 0; k < cnt; k++) send_item(rand_item(60));
    end
    no_gaps = 0;
  endtask

  task automatic test_backpressure();
    write_reg(CFG_JOINT_COUNT, 3);
    rx_style = 0;
    hold_req = 3000;
    for (int k = 0; k < 8; k++) send_item(rand_item(20));
  endtask

  task automatic test_drain_pause();
    for (int k = 0; k < 10; k++) send_item(rand_item(50));
    drain();
    rx_style = 1;
    for (int k = 0; k < 10; k++) send_item(rand_item(50));
  endtask

  // receiver: random stalls, steady accept, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_req > 0) begin
      out_ready <= 1'b0;
      hold_req <= hold_req - 1;
    end else begin
      case (rx_style)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 9) < 3);
      endcase
    end
  end

  always @(posedge clk) begin
    out_t e;
    if (!rst && out_valid && out_ready) begin
      if (joint_q.size() == 0) begin
        $error("unexpected joint transfer: index %0d", out_data.joint_index);
        errors++;
      end else begin
        e = joint_q.pop_front();
        if (out_data.joint_index !== e.joint_index) begin
          $error("joint_index exp %0d got %0d", e.joint_index, out_data.joint_index);
          errors++;
        end
        if (out_data.joint_x !== e.joint_x) begin
          $error("joint_x exp %0d got %0d", e.joint_x, out_data.joint_x);
          errors++;
        end
        if (out_data.joint_y !== e.joint_y) begin
          $error("joint_y exp %0d got %0d", e.joint_y, out_data.joint_y);
          errors++;
        end
        if (out_data.last !== e.last) begin
          $error("last exp %0b got %0b", e.last, out_data.last);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_MAX) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    for (int i = 0; i < NJ; i++) begin
      chain_x[i] = '0;
      chain_y[i] = '0;
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    rx_style = 1;
    test_directed();
    test_random_sweep();
    test_backpressure();
    test_drain_pause();
    drain();
    repeat (50) @(posedge clk);
    if (errors == 0 && joint_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

FILE: fabrik_chain_solver_top.f
sv/fcs_pkg.sv
sv/fcs_ctrl.sv
sv/fcs_dp.sv
sv/fabrik_chain_solver_top.sv
sv/fcs_checker.sv
verif/tb_fabrik_chain_solver_top.sv
